[src/uvsf_pkg.sv]
// uvsf_pkg: shared constants for the uv-sphere face index generator
// no dependencies; used by the top level and its checker

package uvsf_pkg;

  localparam int MAX_LEVEL_DEF = 6;   // default deepest subdivision level
  localparam int LVL_W         = 4;   // holds any level up to the parameter's range
  localparam int CFG_W         = 3;   // subdivision_level register width
  localparam int VTX_W         = 15;  // vertex index field width

endpackage

[src/uv_sphere_face_index_generator.sv]
// uv_sphere_face_index_generator: emits vertex indices of a latitude-longitude
// sphere mesh, one face per transaction. One input register, one result register,
// and the face arithmetic between them. A request is held in the input register,
// its face in the result register. A new request is taken in every cycle; the only
// throughput limit is the result consumer's out_ready. The level register saturates
// at MAX_LEVEL and should be written only while no requests are in flight.
// depends on uvsf_pkg

module uv_sphere_face_index_generator #(
  parameter int MAX_LEVEL = uvsf_pkg::MAX_LEVEL_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [uvsf_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_restart,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_is_quad,
  output logic [uvsf_pkg::VTX_W-1:0] out_vertex_a,
  output logic [uvsf_pkg::VTX_W-1:0] out_vertex_b,
  output logic [uvsf_pkg::VTX_W-1:0] out_vertex_c,
  output logic [uvsf_pkg::VTX_W-1:0] out_vertex_d,
  output logic                     out_last_face
);
  import uvsf_pkg::*;

  localparam int BW = MAX_LEVEL + 1;            // band counter width
  localparam int CW = MAX_LEVEL + 2;            // column counter width
  localparam int VW = (2 * MAX_LEVEL + 4 > VTX_W) ? 2 * MAX_LEVEL + 4 : VTX_W;

  logic [CFG_W-1:0] level_r;
  logic             s1_valid_r;
  logic             s1_restart_r;
  logic             out_valid_r;
  logic [BW-1:0]    band_r, band_nxt;
  logic [CW-1:0]    col_r, col_nxt;

  logic             out_quad_r, out_quad_nxt;
  logic             out_last_r, out_last_nxt;
  logic [VTX_W-1:0] out_a_r, out_a_nxt;
  logic [VTX_W-1:0] out_b_r, out_b_nxt;
  logic [VTX_W-1:0] out_c_r, out_c_nxt;
  logic [VTX_W-1:0] out_d_r, out_d_nxt;

  logic             s2_load;
  logic [LVL_W-1:0] lvl;

  assign s2_load  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s2_load;

  // saturate the level at the deepest supported subdivision
  always_comb begin
    if ({{(LVL_W-CFG_W){1'b0}}, level_r} > LVL_W'(MAX_LEVEL)) begin
      lvl = LVL_W'(MAX_LEVEL);
    end else begin
      lvl = {{(LVL_W-CFG_W){1'b0}}, level_r};
    end
  end

  // face geometry from the band and column counters
  always_comb begin
    logic [LVL_W-1:0] csh;
    logic [BW-1:0]    bands_m1;
    logic [CW-1:0]    cols_m1;
    logic [BW-1:0]    k;
    logic [CW-1:0]    j;
    logic [VW-1:0]    cols, pole, s, e, jv, a, b, c, d;
    logic             quad;

    csh      = lvl + LVL_W'(2);
    bands_m1 = ~({BW{1'b1}} << (lvl + LVL_W'(1)));
    cols_m1  = ~({CW{1'b1}} << csh);

    // out-of-range counters (level lowered mid-sequence) also restart
    if (s1_restart_r || band_r > bands_m1 || col_r > cols_m1) begin
      k = '0;
      j = '0;
    end else begin
      k = band_r;
      j = col_r;
    end

    cols = VW'(1) << csh;
    pole = (VW'(bands_m1) << csh) + VW'(1);
    s    = (VW'(k - BW'(1)) << csh) + VW'(1);
    e    = VW'(k) << csh;
    jv   = VW'(j);
    quad = 1'b0;
    d    = '0;

    if (k == '0) begin
      a = '0;
      if (j == '0) begin
        b = cols;
        c = VW'(1);
      end else begin
        b = jv;
        c = jv + VW'(1);
      end
    end else if (k == bands_m1) begin
      b = pole;
      if (j == '0) begin
        a = e;
        c = s;
      end else begin
        a = s + jv - VW'(1);
        c = s + jv;
      end
    end else begin
      quad = 1'b1;
      if (j == '0) begin
        a = e;
        b = e + cols;
        c = s + cols;
        d = s;
      end else begin
        a = s + jv - VW'(1);
        b = s + jv - VW'(1) + cols;
        c = s + jv + cols;
        d = s + jv;
      end
    end

    out_quad_nxt = quad;
    out_a_nxt    = a[VTX_W-1:0];
    out_b_nxt    = b[VTX_W-1:0];
    out_c_nxt    = c[VTX_W-1:0];
    out_d_nxt    = d[VTX_W-1:0];
    out_last_nxt = (k == bands_m1) && (j == cols_m1);

    if (j == cols_m1) begin
      col_nxt  = '0;
      band_nxt = (k == bands_m1) ? '0 : k + BW'(1);
    end else begin
      col_nxt  = j + CW'(1);
      band_nxt = k;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r     <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      band_r      <= '0;
      col_r       <= '0;
    end else begin
      if (cfg_we) begin
        level_r <= cfg_wdata;
      end
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s2_load) begin
        out_valid_r <= 1'b1;
        band_r      <= band_nxt;
        col_r       <= col_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_restart_r <= in_restart;
    end
    if (s2_load) begin
      out_quad_r <= out_quad_nxt;
      out_a_r    <= out_a_nxt;
      out_b_r    <= out_b_nxt;
      out_c_r    <= out_c_nxt;
      out_d_r    <= out_d_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_is_quad   = out_quad_r;
  assign out_vertex_a  = out_a_r;
  assign out_vertex_b  = out_b_r;
  assign out_vertex_c  = out_c_r;
  assign out_vertex_d  = out_d_r;
  assign out_last_face = out_last_r;

endmodule

[src/uvsf_checker.sv]
// uvsf_checker: port-level assertions for uv_sphere_face_index_generator
// depends on uvsf_pkg; bound to the top level at the end of this file

module uvsf_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       out_is_quad,
  input logic [uvsf_pkg::VTX_W-1:0] out_vertex_a,
  input logic [uvsf_pkg::VTX_W-1:0] out_vertex_b,
  input logic [uvsf_pkg::VTX_W-1:0] out_vertex_c,
  input logic [uvsf_pkg::VTX_W-1:0] out_vertex_d,
  input logic                       out_last_face
);
  import uvsf_pkg::*;

  // a stalled result holds its face
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_vertex_a) &&
      $stable(out_vertex_b) && $stable(out_vertex_c) && $stable(out_vertex_d))
    else $error("result changed while stalled");

  // triangles carry no fourth vertex
  a_tri_d_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_quad |-> out_vertex_d == '0)
    else $error("triangle with nonzero fourth vertex");

  // the final face sits in the south fan, never at the north pole
  a_last_tri: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_face |-> !out_is_quad && out_vertex_a != '0)
    else $error("last face is not a south fan triangle");

  // with no result waiting the input side always has room
  a_ready_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with no result waiting");

  // nothing comes out in the cycle after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind uv_sphere_face_index_generator uvsf_checker u_uvsf_checker (.*);

[test/testbench.sv]
// testbench for uv_sphere_face_index_generator: drives face requests, predicts each face
// from its own model of the mesh walk and compares every returned face field by field
// depends on uvsf_pkg and the generator rtl
`timescale 1ns / 100ps

module testbench;
  import uvsf_pkg::*;

  typedef logic [VTX_W-1:0] vtx_t;

  typedef struct packed {
    logic is_quad;
    vtx_t vertex_a;
    vtx_t vertex_b;
    vtx_t vertex_c;
    vtx_t vertex_d;
    logic last_face;
  } face_t;

  logic             clk         = 1'b0;
  logic             rst_n       = 1'b0;
  logic             cfg_we      = 1'b0;
  logic [CFG_W-1:0] cfg_wdata   = '0;
  logic             in_valid    = 1'b0;
  logic             in_ready;
  logic             in_restart  = 1'b0;
  logic             out_valid;
  logic             out_ready   = 1'b0;
  logic             out_is_quad;
  vtx_t             out_vertex_a;
  vtx_t             out_vertex_b;
  vtx_t             out_vertex_c;
  vtx_t             out_vertex_d;
  logic             out_last_face;

  // mirror of the generator state
  logic [CFG_W-1:0] level_reg = '0;
  logic [6:0]       band_q    = '0;
  logic [7:0]       col_q     = '0;

  face_t pending_faces[$];
  int    mismatch_count = 0;
  bit    idling_on      = 1'b1;
  int    sink_hold      = 0;

  uv_sphere_face_index_generator dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_restart   (in_restart),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_is_quad  (out_is_quad),
    .out_vertex_a (out_vertex_a),
    .out_vertex_b (out_vertex_b),
    .out_vertex_c (out_vertex_c),
    .out_vertex_d (out_vertex_d),
    .out_last_face(out_last_face)
  );

  always #5 clk = ~clk;

  // works out the face for one request and advances the band / column walk
  function automatic face_t next_face(input logic restart);
    int    lvl, cols, bands, pole, k, j, s, e;
    face_t f;
    lvl   = (int'(level_reg) > MAX_LEVEL_DEF) ? MAX_LEVEL_DEF : int'(level_reg);
    cols  = 1 << (lvl + 2);
    bands = 1 << (lvl + 1);
    pole  = (bands - 1) * cols + 1;
    // counters left out of range by a lowered level start over as well
    if (restart || int'(band_q) >= bands || int'(col_q) >= cols) begin
      band_q = '0;
      col_q  = '0;
    end
    k = int'(band_q);
    j = int'(col_q);
    s = (k - 1) * cols + 1;
    e = k * cols;
    f = '0;
    if (k == 0) begin
      f.vertex_b = vtx_t'((j == 0) ? cols : j);
      f.vertex_c = vtx_t'(j + 1);
    end else if (k == bands - 1) begin
      f.vertex_a = vtx_t'((j == 0) ? e : s + j - 1);
      f.vertex_b = vtx_t'(pole);
      f.vertex_c = vtx_t'(s + j);
    end else begin
      f.is_quad  = 1'b1;
      f.vertex_a = vtx_t'((j == 0) ? e : s + j - 1);
      f.vertex_b = vtx_t'(((j == 0) ? e : s + j - 1) + cols);
      f.vertex_c = vtx_t'(s + j + cols);
      f.vertex_d = vtx_t'(s + j);
    end
    f.last_face = (k == bands - 1) && (j == cols - 1);
    if (j + 1 >= cols) begin
      col_q  = '0;
      band_q = (k + 1 >= bands) ? 7'd0 : 7'(k + 1);
    end else begin
      col_q = 8'(j + 1);
    end
    return f;
  endfunction

  // result checking first, so a face is never matched against a request of the same edge
  always @(posedge clk) begin : face_monitor
    face_t want;
    face_t got;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got = '{out_is_quad, out_vertex_a, out_vertex_b, out_vertex_c, out_vertex_d,
                out_last_face};
        if (pending_faces.size() == 0) begin
          $display("%0t: face with no request outstanding: %p", $time, got);
          mismatch_count++;
        end else begin
          want = pending_faces.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (got.is_quad !== want.is_quad)
              $display("%0t: is_quad expected %0d actual %0d", $time, want.is_quad,
                       got.is_quad);
            if (got.vertex_a !== want.vertex_a)
              $display("%0t: vertex_a expected %0d actual %0d", $time, want.vertex_a,
                       got.vertex_a);
            if (got.vertex_b !== want.vertex_b)
              $display("%0t: vertex_b expected %0d actual %0d", $time, want.vertex_b,
                       got.vertex_b);
            if (got.vertex_c !== want.vertex_c)
              $display("%0t: vertex_c expected %0d actual %0d", $time, want.vertex_c,
                       got.vertex_c);
            if (got.vertex_d !== want.vertex_d)
              $display("%0t: vertex_d expected %0d actual %0d", $time, want.vertex_d,
                       got.vertex_d);
            if (got.last_face !== want.last_face)
              $display("%0t: last_face expected %0d actual %0d", $time, want.last_face,
                       got.last_face);
          end
        end
      end
      if (in_valid && in_ready)
        pending_faces.push_back(next_face(in_restart));
      if (cfg_we)
        level_reg = cfg_wdata;
    end
  end

  // consumer back-pressure in random bursts while idling is on, else always ready
  always @(posedge clk) begin
    if (!idling_on) begin
      out_ready <= 1'b1;
      sink_hold <= 0;
    end else if (sink_hold != 0) begin
      sink_hold <= sink_hold - 1;
    end else begin
      out_ready <= 1'($urandom_range(0, 1));
      sink_hold <= $urandom_range(0, 14);
    end
  end

  task automatic send_request(input logic restart);
    if (idling_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_restart <= restart;
    do @(posedge clk); while (!in_ready);
  endtask

  // stop sending and let every outstanding face come back
  task automatic drain_faces();
    in_valid <= 1'b0;
    while (pending_faces.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_level(input logic [CFG_W-1:0] lvl);
    cfg_we    <= 1'b1;
    cfg_wdata <= lvl;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // level 0 out of reset: north fan, south fan, last face, then wrap
  task automatic test_reset_level_mesh();
    for (int i = 0; i < 10; i++) send_request(1'b0);
    drain_faces();
  endtask

  // raise the level mid-walk, then restart and walk into the first quad band
  task automatic test_restart_into_quads();
    write_level(3'd1);
    for (int i = 0; i < 14; i++) send_request(i == 2);
    drain_faces();
  endtask

  // lowering the level leaves the column out of range, so the walk starts over
  task automatic test_level_lowered();
    write_level(3'd0);
    send_request(1'b0);
    send_request(1'b0);
    drain_faces();
  endtask

  task automatic test_random_walks();
    int sent;
    int n;
    int r;
    bit noisy;
    sent = 0;
    while (sent < 340) begin
      drain_faces();
      r = $urandom_range(0, 9);
      write_level((r < 7) ? 3'($urandom_range(0, 3)) : 3'($urandom_range(4, 7)));
      n     = $urandom_range(15, 70);
      noisy = ($urandom_range(0, 4) == 0);
      for (int i = 0; i < n; i++)
        send_request(noisy ? ($urandom_range(0, 2) == 0) : ($urandom_range(0, 39) == 0));
      sent += n;
    end
    drain_faces();
  endtask

  // start of the north fan at the deepest level through a saturating register value,
  // then the same walk carried on under the in-range level, no idling
  task automatic test_deepest_mesh();
    idling_on = 1'b0;
    write_level(3'd7);
    send_request(1'b1);
    for (int i = 0; i < 60; i++) send_request(1'b0);
    drain_faces();
    write_level(3'(MAX_LEVEL_DEF));
    for (int i = 0; i < 3; i++) send_request(1'b0);
    drain_faces();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_level_mesh();
    test_restart_into_quads();
    test_level_lowered();
    test_random_walks();
    test_deepest_mesh();
    if (mismatch_count == 0 && pending_faces.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
